@@ hdl/wmcp_pkg.sv @@
// ----------------------------------------------------------------------------
// wmcp_pkg: shared types and sizes for the windowed min-cost path unit
// Widths of heights, costs and candidates, and the sizes of the cell row
// and of the min tree.
// ----------------------------------------------------------------------------
package wmcp_pkg;

    localparam int MAX_REACH   = 16;
    localparam int HEIGHT_W    = 16;
    localparam int COST_W      = 32;
    localparam int CAND_W      = COST_W + 1;
    localparam int REACH_CFG_W = 5;
    localparam int REACH_RESET = 2;

    // Wide enough to hold MAX_REACH itself
    localparam int REACH_W     = $clog2(MAX_REACH + 1);

    // Min tree: at least one level, leaves padded to a power of two
    localparam int TREE_LEVELS = (MAX_REACH > 1) ? $clog2(MAX_REACH) : 1;
    localparam int TREE_N      = 1 << TREE_LEVELS;

    typedef logic [HEIGHT_W-1:0]    height_t;
    typedef logic [COST_W-1:0]      cost_t;
    typedef logic [CAND_W-1:0]      cand_t;
    typedef logic [REACH_W-1:0]     reach_t;
    typedef logic [REACH_CFG_W-1:0] reach_cfg_t;

    localparam cand_t CAND_NONE = '1;
    localparam cost_t COST_MAX  = '1;

endpackage

@@ hdl/wmcp_cell.sv @@
// ----------------------------------------------------------------------------
// wmcp_cell: one history slot of the path unit
// Holds one earlier stone's height and cost, forms the candidate cost of a
// jump from it to the new stone, and hands its contents on along the row.
// ----------------------------------------------------------------------------
module wmcp_cell (
    input  logic              aclk,
    input  logic              capture,
    input  logic              enable,
    input  wmcp_pkg::height_t new_height,
    input  logic              push,
    input  wmcp_pkg::height_t height_in,
    input  wmcp_pkg::cost_t   cost_in,
    output wmcp_pkg::height_t height_out,
    output wmcp_pkg::cost_t   cost_out,
    output wmcp_pkg::cand_t   cand_out
);
    import wmcp_pkg::*;

    height_t height_reg;
    cost_t   cost_reg;
    cand_t   cand_reg;
    height_t diff;

    assign diff = (new_height >= height_reg) ? (new_height - height_reg)
                                             : (height_reg - new_height);

    always_ff @(posedge aclk) begin
        if (push) begin
            height_reg <= height_in;
            cost_reg   <= cost_in;
        end
        if (capture) begin
            // a slot out of reach never wins the minimum
            cand_reg <= enable ? (CAND_W'(cost_reg) + CAND_W'(diff)) : CAND_NONE;
        end
    end

    assign height_out = height_reg;
    assign cost_out   = cost_reg;
    assign cand_out   = cand_reg;

endmodule

@@ hdl/wmcp_min_tree.sv @@
// ----------------------------------------------------------------------------
// wmcp_min_tree: registered minimum over the candidates of the cell row
// Pairwise minimum, one register level per tree level; the result is
// taken from the register at the root.
// ----------------------------------------------------------------------------
module wmcp_min_tree (
    input  logic            aclk,
    input  wmcp_pkg::cand_t cand [wmcp_pkg::MAX_REACH],
    output wmcp_pkg::cand_t min_out
);
    import wmcp_pkg::*;

    cand_t leaf [TREE_N];
    cand_t node_reg [1:TREE_N-1];

    // pad the unused leaves so they never win
    always_comb begin
        for (int i = 0; i < TREE_N; i++) begin
            leaf[i] = (i < MAX_REACH) ? cand[i] : CAND_NONE;
        end
    end

    for (genvar n = 1; n < TREE_N; n++) begin : g_node
        cand_t a;
        cand_t b;
        if (2 * n >= TREE_N) begin : g_leaf
            assign a = leaf[2 * n - TREE_N];
            assign b = leaf[2 * n + 1 - TREE_N];
        end else begin : g_inner
            assign a = node_reg[2 * n];
            assign b = node_reg[2 * n + 1];
        end
        always_ff @(posedge aclk) begin
            node_reg[n] <= (b < a) ? b : a;
        end
    end

    assign min_out = node_reg[1];

endmodule

@@ hdl/windowed_min_cost_path_dp_unit.sv @@
// ----------------------------------------------------------------------------
// windowed_min_cost_path_dp_unit: least-cost path over a stream of stones
// Row of history cells, registered min tree, saturating cost and a result
// register on the master side.
// ----------------------------------------------------------------------------
// For every stone height taken on the slave stream the unit returns one
// transaction carrying the least total cost of reaching that stone from the
// first stone of the current path, where one jump spans 1 to jump_reach
// stones and costs the absolute height difference. path_start on s_tuser
// opens a new path (cost 0); so does the first stone after reset. A
// jump_reach of 0 acts as 1 and a value above 16 acts as 16. Costs clip at
// 0xFFFFFFFF with m_tuser set. One stone is in work at a time, whatever the
// reach: the cells register their candidates, the minimum passes each min
// tree level in turn, and the cost is folded back into the cell row, which
// the next stone needs. The result register lets the next stone enter while
// a result still waits on m_tready.
// Write jump_reach only while the unit is idle.
// ----------------------------------------------------------------------------
module windowed_min_cost_path_dp_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_we,
    input  wmcp_pkg::reach_cfg_t cfg_wdata,     // jump_reach
    // slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,       // [15:0] stone_height
    input  logic                 s_tuser,       // [0] path_start
    // master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,       // [31:0] path_cost
    output logic                 m_tuser        // [0] cost_saturated
);
    import wmcp_pkg::*;

    localparam int CNT_W = $clog2(TREE_LEVELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    reach_cfg_t reach_reg;
    reach_t     seen_reg, seen_next;
    logic       first_reg;
    height_t    height_reg;
    logic       m_valid_reg;
    cost_t      m_cost_reg;
    logic       m_sat_reg;

    logic       s_accept;
    logic       finish;
    reach_t     k_clamp;
    reach_t     k_eff;
    logic       enable [MAX_REACH];
    cand_t      cand [MAX_REACH];
    height_t    chain_height [MAX_REACH+1];
    cost_t      chain_cost [MAX_REACH+1];
    cand_t      best;
    cost_t      new_cost;
    logic       new_sat;

    // take a new stone only between stones
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    // fold the result back once the result register is free
    assign finish   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // Effective reach: clamp the setting, then limit to the history held
    always_comb begin
        if (reach_reg == '0) begin
            k_clamp = reach_t'(1);
        end else if (32'(reach_reg) > MAX_REACH) begin
            k_clamp = reach_t'(MAX_REACH);
        end else begin
            k_clamp = reach_t'(reach_reg);
        end
        k_eff = (seen_reg < k_clamp) ? seen_reg : k_clamp;
    end

    // Cell row: slot 0 holds the newest stone
    assign chain_height[0] = height_reg;
    assign chain_cost[0]   = new_cost;

    for (genvar j = 0; j < MAX_REACH; j++) begin : g_cell
        assign enable[j] = (reach_t'(j) < k_eff);
        wmcp_cell u_cell (
            .aclk       (aclk),
            .capture    (s_accept),
            .enable     (enable[j]),
            .new_height (s_tdata),
            .push       (finish),
            .height_in  (chain_height[j]),
            .cost_in    (chain_cost[j]),
            .height_out (chain_height[j+1]),
            .cost_out   (chain_cost[j+1]),
            .cand_out   (cand[j])
        );
    end

    wmcp_min_tree u_min_tree (
        .aclk    (aclk),
        .cand    (cand),
        .min_out (best)
    );

    // Clip the minimum; the first stone of a path costs nothing
    always_comb begin
        if (first_reg) begin
            new_cost = '0;
            new_sat  = 1'b0;
        end else if (best[CAND_W-1]) begin
            new_cost = COST_MAX;
            new_sat  = 1'b1;
        end else begin
            new_cost = best[COST_W-1:0];
            new_sat  = 1'b0;
        end
    end

    // Sequencer: wait out the tree levels, then hand over the result
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TREE_LEVELS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // History depth: restart at one on a new path, saturate at the row length
    always_comb begin
        seen_next = seen_reg;
        if (finish) begin
            if (first_reg) begin
                seen_next = reach_t'(1);
            end else if (seen_reg < reach_t'(MAX_REACH)) begin
                seen_next = seen_reg + reach_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            reach_reg   <= reach_cfg_t'(REACH_RESET);
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
            if (cfg_we) begin
                reach_reg <= cfg_wdata;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the stone in work and the result on offer
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            height_reg <= s_tdata;
            first_reg  <= s_tuser || (seen_reg == '0);
        end
        if (finish) begin
            m_cost_reg <= new_cost;
            m_sat_reg  <= new_sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_cost_reg;
    assign m_tuser  = m_sat_reg;

`ifndef ASSERT_OFF
    // The history depth never runs past the row of cells
    assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= reach_t'(MAX_REACH))
        else $error("history depth exceeds cell count");

    // A clipped cost is always the top of the range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == COST_MAX))
        else $error("saturation flag without clipped cost");

    // Only one stone in work: an accepted transaction closes the slave side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second stone taken while one is in work");

    // A finished stone always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (m_tvalid && !s_tready && $past(state_reg) == ST_DONE)
                   || (m_tvalid && s_tready))
        else $error("finished result not offered");
`endif

endmodule

@@ bench/wmcp_path_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wmcp_path_checker: result checker for the windowed min-cost path unit
// Watches both streams and the reach register, predicts each path cost as
// stones are taken, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module wmcp_path_checker
    import wmcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  reach_cfg_t  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,        // [15:0] stone_height
    input  logic        s_tuser,        // [0] path_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,        // [31:0] path_cost
    input  logic        m_tuser,        // [0] cost_saturated
    input  logic        run_done,
    output int          pending_cnt,
    output int          fail_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        cost_t cost;
        logic  sat;
    } path_result_t;

    reach_cfg_t   reach_reg;
    height_t      height_hist [MAX_REACH];
    cost_t        cost_hist [MAX_REACH];
    int unsigned  stones_held;
    path_result_t cost_expect_q [$];
    int           mismatches;

    // Expectations still queued at the end count as failures
    assign fail_count = mismatches + (run_done ? pending_cnt : 0);

    // Cost of the next stone; advances the history window as a side effect
    function automatic path_result_t next_path_cost(height_t h, logic start);
        path_result_t res;
        int unsigned  reach;
        cand_t        best;
        cand_t        cand;
        height_t      climb;
        res = '0;
        if (start || stones_held == 0) begin
            stones_held = 0;
        end else begin
            reach = (reach_reg == 0) ? 1 : int'(reach_reg);
            if (reach > MAX_REACH)
                reach = MAX_REACH;
            if (reach > stones_held)
                reach = stones_held;
            best = '1;
            for (int j = 0; j < reach; j++) begin
                climb = (h >= height_hist[j]) ? h - height_hist[j] : height_hist[j] - h;
                cand = cand_t'(cost_hist[j]) + cand_t'(climb);
                if (cand < best)
                    best = cand;
            end
            if (best > cand_t'(COST_MAX)) begin
                res.cost = COST_MAX;
                res.sat  = 1'b1;
            end else begin
                res.cost = best[COST_W-1:0];
            end
        end
        for (int i = MAX_REACH - 1; i > 0; i--) begin
            height_hist[i] = height_hist[i-1];
            cost_hist[i]   = cost_hist[i-1];
        end
        height_hist[0] = h;
        cost_hist[0]   = res.cost;
        if (stones_held < MAX_REACH)
            stones_held++;
        return res;
    endfunction

    always @(posedge aclk) begin
        path_result_t want;
        if (!aresetn) begin
            reach_reg   = reach_cfg_t'(REACH_RESET);
            stones_held = 0;
            for (int i = 0; i < MAX_REACH; i++) begin
                height_hist[i] = '0;
                cost_hist[i]   = '0;
            end
            cost_expect_q.delete();
            mismatches = 0;
        end else begin
            // results first: a stone taken at this edge cannot have left yet
            if (m_tvalid && m_tready) begin
                if (cost_expect_q.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: unexpected result cost=%h sat=%b",
                                 $realtime, m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = cost_expect_q.pop_front();
                    if (m_tdata !== want.cost || m_tuser !== want.sat) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("%0t: cost mismatch: expected %h/%b, got %h/%b",
                                     $realtime, want.cost, want.sat, m_tdata, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                cost_expect_q.push_back(next_path_cost(s_tdata, s_tuser));
            if (cfg_we)
                reach_reg = cfg_wdata;
        end
        pending_cnt <= cost_expect_q.size();
    end

endmodule

@@ bench/tb_windowed_min_cost_path_dp_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_min_cost_path_dp_unit: stream test of the min-cost path unit
// Drives stone heights through the slave stream under a range of jump
// reaches, with random gaps and back-pressure, and leaves all checking of
// the result stream to a separate checker.
// ----------------------------------------------------------------------------
module tb_windowed_min_cost_path_dp_unit;
    import wmcp_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 3;
    localparam int PHASE_STONES    = 200;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int TAIL_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    reach_cfg_t  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    logic        run_done;
    int          pending_cnt;
    int          fail_count;

    // Stimulus knobs; the receiver process reads the stall and hold-off knobs
    bit          tx_gaps_on;
    bit          rx_stalls_on;
    bit          hold_off_req;
    height_t     path_base;

    windowed_min_cost_path_dp_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    wmcp_path_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .run_done    (run_done),
        .pending_cnt (pending_cnt),
        .fail_count  (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Mostly no gap or a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom_range(20, 60);
        else if (r < 40)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Mix extremes, full-range noise and a cluster near the path's base
    // height, so that several jump candidates compete for the minimum
    function automatic height_t rand_height();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                return 16'h0000;
            end
            1: begin
                return 16'hFFFF;
            end
            2, 3, 4: begin
                return height_t'($urandom_range(0, 65535));
            end
            default: begin
                return path_base + height_t'($urandom_range(0, 63));
            end
        endcase
    endfunction

    // Offer one stone and hold it until the transaction completes. The
    // first negedge after acceptance always either carries the next stone
    // or drops tvalid, so nothing is taken twice.
    task automatic send_stone(input height_t h, input logic start);
        int unsigned gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid and wait until every result is back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cnt != 0) @(negedge aclk);
    endtask

    // Write the reach only with the unit idle
    task automatic write_reach(input reach_cfg_t value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count);
        logic start;
        for (int unsigned i = 0; i < count; i++) begin
            start = ($urandom_range(0, 19) == 0);
            if (start)
                path_base = height_t'($urandom_range(0, 65535 - 64));
            send_stone(rand_height(), start);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : rx_proc
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                // hold off while the sender keeps pushing, so the unit backs up
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end else if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        reach_cfg_t phase_reach [8];
        phase_reach = '{5'd0, 5'd1, 5'd3, 5'd16, 5'd17, 5'd31, 5'd7, 5'd2};

        // Drive every input to a known value before the first edge
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        run_done     = 1'b0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        hold_off_req = 1'b0;
        path_base    = '0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset reach of 2. The first stone after
        // reset opens a path even without path_start; the second stone
        // sees a history one deep, so its reach shrinks to one.
        send_stone(16'h1234, 1'b0);
        send_stone(16'hFFFF, 1'b0);
        send_stone(16'h0000, 1'b0);
        send_stone(16'hFFFF, 1'b0);
        send_stone(16'h0000, 1'b0);
        send_stone(16'h0000, 1'b0);
        // new path mid-stream, then a zero-height step and mid-range bits
        send_stone(16'hFFFF, 1'b1);
        send_stone(16'hFFFF, 1'b0);
        send_stone(16'h8000, 1'b0);
        send_stone(16'h7FFF, 1'b0);
        send_stone(16'h0001, 1'b0);
        send_stone(16'hFFFE, 1'b0);
        // back-to-back path starts
        send_stone(16'h5555, 1'b1);
        send_stone(16'hAAAA, 1'b1);
        send_stone(16'h5555, 1'b0);

        // A reach of zero must behave as a reach of one
        write_reach(5'd0);
        send_stone(16'h0000, 1'b1);
        send_stone(16'h0064, 1'b0);
        send_stone(16'h0000, 1'b0);
        send_stone(16'h0064, 1'b0);

        // Random phases over a spread of reaches, extremes included
        for (int p = 0; p < 8; p++) begin
            write_reach(phase_reach[p]);
            if (phase_reach[p] == 5'd16) begin
                // long receiver hold-off against a sender with no gaps
                tx_gaps_on   = 1'b0;
                hold_off_req = 1'b1;
                run_random(PHASE_STONES);
                tx_gaps_on   = 1'b1;
            end else begin
                run_random(PHASE_STONES);
            end
        end

        // Short closing path at the reset reach
        write_reach(5'd2);
        send_stone(16'h0000, 1'b0);
        send_stone(16'h0010, 1'b1);
        send_stone(16'h0020, 1'b0);

        // Wind down: wait for the last results, then a short tail
        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        run_done = 1'b1;
        @(negedge aclk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
